[rtl/texture_additive_blend_fragment_assert.svh]
// Assertion macros for the checker of the texture blend fragment unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TEXTURE_ADDITIVE_BLEND_FRAGMENT_ASSERT_SVH
`define TEXTURE_ADDITIVE_BLEND_FRAGMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TABF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tabf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TABF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tabf assertion failed");

`endif

[rtl/tabf_pkg.sv]
// Constants, widths and the RGB565 saturating blend for the texture blend fragment unit.
// Depends on nothing; used by the top level, the checker and the testbench.
package tabf_pkg;

    localparam int TEX_LOG2_DEF   = 8;
    localparam int COORD_FRAC_W   = 24;
    localparam int FB_WIDTH_W     = 11;
    localparam logic [FB_WIDTH_W-1:0] FB_WIDTH_RESET = 11'd320;

    localparam int TEXEL_W        = 16;
    localparam int POS_W          = 10;
    localparam int COORD_W        = 32;
    localparam int ADDR_W         = 20;

    localparam int S_DATA_W       = 136;
    localparam int M_DATA_W       = 40;

    localparam logic [TEXEL_W:0] CARRY_MASK = 17'h10820;

    function automatic logic [TEXEL_W-1:0] blend_sat565(
        input logic [TEXEL_W-1:0] dst,
        input logic [TEXEL_W-1:0] src
    );
        logic [TEXEL_W:0] sum;
        logic [TEXEL_W:0] carry;
        logic [TEXEL_W:0] fill;
        sum   = {1'b0, dst} + {1'b0, src};
        carry = (sum ^ {1'b0, dst} ^ {1'b0, src}) & CARRY_MASK;
        sum   = sum - carry;
        fill  = carry - (carry >> 5);
        sum   = sum | fill;
        return sum[TEXEL_W-1:0];
    endfunction

endpackage

[rtl/tabf_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; holds the texture store.
module tabf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/texture_additive_blend_fragment.sv]
// Top level of the texture blend fragment unit: texel loads, nearest fetch and RGB565 add.
// Depends on tabf_pkg and tabf_ram.
//
//   channel  direction  accepted when           carries
//   s_       in         s_tvalid & s_tready     load or fragment request
//   m_       out        m_tvalid & m_tready     pixel address, colour, write enable
//   cfg_     in         cfg_valid & cfg_ready   framebuffer row length
//
// One request is taken every cycle while the output is not stalled.
// The first stage reads the texture RAM and multiplies the row by the width,
// the second adds the column and forms the blended colour into the output register.
// A stall on the output holds both stages and the RAM read data in place.
// Reset clears the valid flags and sets the row length to 320; the RAM is not cleared.
module texture_additive_blend_fragment #(
    parameter int TEX_LOG2 = tabf_pkg::TEX_LOG2_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // texel_index, texel_value, pos_x, pos_y, tex_u, tex_v, dest_color, zero fill
    input  logic [tabf_pkg::S_DATA_W-1:0]   s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_address, new_color, zero fill
    output logic [tabf_pkg::M_DATA_W-1:0]   m_tdata,
    // write_enable
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tabf_pkg::FB_WIDTH_W-1:0] cfg_data
);
    import tabf_pkg::*;

    localparam int IDX_W = 2 * TEX_LOG2;
    localparam int DEPTH = 1 << IDX_W;
    localparam int PROD_W = POS_W + FB_WIDTH_W;

    logic [TEXEL_W-1:0]    texel_index;
    logic [TEXEL_W-1:0]    texel_value;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [COORD_W-1:0]    tex_u;
    logic [COORD_W-1:0]    tex_v;
    logic [TEXEL_W-1:0]    dest_color;

    logic                  accept;
    logic                  advance;
    logic [IDX_W+TEXEL_W-1:0] load_ext;
    logic [IDX_W-1:0]      load_idx;
    logic [IDX_W-1:0]      frag_idx;
    logic [PROD_W-1:0]     prod;
    logic [TEXEL_W-1:0]    texel;

    logic [FB_WIDTH_W-1:0] fb_width_reg;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_shade_reg;
    logic [ADDR_W-1:0]     s1_prod_reg;
    logic [POS_W-1:0]      s1_x_reg;
    logic [TEXEL_W-1:0]    s1_dest_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [ADDR_W-1:0]     out_addr_next;
    logic [TEXEL_W-1:0]    out_color_reg;
    logic [TEXEL_W-1:0]    out_color_next;
    logic                  out_we_reg;
    logic                  out_we_next;

    assign texel_index = s_tdata[15:0];
    assign texel_value = s_tdata[31:16];
    assign pos_x       = s_tdata[41:32];
    assign pos_y       = s_tdata[51:42];
    assign tex_u       = s_tdata[83:52];
    assign tex_v       = s_tdata[115:84];
    assign dest_color  = s_tdata[131:116];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign load_ext = {{IDX_W{1'b0}}, texel_index};
    assign load_idx = load_ext[IDX_W-1:0];
    assign frag_idx = {tex_v[COORD_FRAC_W-1 -: TEX_LOG2], tex_u[COORD_FRAC_W-1 -: TEX_LOG2]};
    assign prod     = PROD_W'(pos_y) * PROD_W'(fb_width_reg);

    tabf_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (DEPTH)
    ) u_tex_ram (
        .clk   (clk),
        .we    (accept && !s_tuser),
        .waddr (load_idx),
        .wdata (texel_value),
        .re    (accept && s_tuser),
        .raddr (frag_idx),
        .rdata (texel)
    );

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        out_addr_next  = '0;
        out_color_next = '0;
        out_we_next    = 1'b0;
        if (s1_shade_reg)
        begin
            out_addr_next = s1_prod_reg + ADDR_W'(s1_x_reg);
            if (texel != '0)
            begin
                out_color_next = blend_sat565(s1_dest_reg, texel);
                out_we_next    = 1'b1;
            end
            else
            begin
                out_color_next = s1_dest_reg;
            end
        end
    end

    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= FB_WIDTH_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fb_width_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_shade_reg <= s_tuser;
            s1_prod_reg  <= prod[ADDR_W-1:0];
            s1_x_reg     <= pos_x;
            s1_dest_reg  <= dest_color;
        end
        if (advance && s1_valid_reg)
        begin
            out_addr_reg  <= out_addr_next;
            out_color_reg <= out_color_next;
            out_we_reg    <= out_we_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_color_reg, out_addr_reg};
    assign m_tuser  = out_we_reg;

endmodule

[rtl/tabf_checker.sv]
// Port-level checker for the texture blend fragment unit, bound to the top level.
// Depends on tabf_pkg and texture_additive_blend_fragment_assert.svh.
`include "texture_additive_blend_fragment_assert.svh"

module tabf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tabf_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import tabf_pkg::*;

    // A stalled result keeps its content.
    `TABF_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A written pixel never carries black, since the texel was nonzero.
    `TABF_ASSERT_IMP(a_we_colour, clk, rst_n, m_tvalid && m_tuser, m_tdata[35:20] != '0)

    // A result appears only after a request was taken.
    `TABF_ASSERT_IMP(a_latency, clk, rst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

    // With an empty output the unit always takes requests.
    `TABF_ASSERT_IMP(a_ready_free, clk, rst_n, !m_tvalid, s_tready)

endmodule

bind texture_additive_blend_fragment tabf_checker u_tabf_checker (.*);

[tb/texture_additive_blend_fragment_test.sv]
// Self-checking testbench for the texture blend fragment unit: texel loads, nearest fetch, RGB565 add.
// Depends on tabf_pkg and texture_additive_blend_fragment; predicts every result in step with the stimulus.
`timescale 1ns / 1ps

module texture_additive_blend_fragment_test;

    import tabf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_PAUSE      = 10;
    localparam logic [31:0] CHANNEL_CARRIES = 32'h0001_0820;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_SHADE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [3:0]         pad;
        logic [TEXEL_W-1:0] dest_color;
        logic [COORD_W-1:0] tex_v;
        logic [COORD_W-1:0] tex_u;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_x;
        logic [TEXEL_W-1:0] texel_value;
        logic [TEXEL_W-1:0] texel_index;
    } shade_request_t;

    typedef struct packed
    {
        logic [3:0]         pad;
        logic [TEXEL_W-1:0] new_color;
        logic [ADDR_W-1:0]  pixel_address;
    } pixel_word_t;

    typedef struct
    {
        logic [ADDR_W-1:0]  pixel_address;
        logic [TEXEL_W-1:0] new_color;
        logic               write_enable;
    } pixel_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = FUNC_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [FB_WIDTH_W-1:0] cfg_data = '0;

    // Predictor state: texel store and row length as the block should hold them.
    logic [TEXEL_W-1:0]    texel_mem [0:65535];
    logic [FB_WIDTH_W-1:0] row_length = FB_WIDTH_RESET;
    pixel_write_t          expected_pixels[$];

    // Stimulus bookkeeping: which texels have been loaded.
    bit                    texel_loaded [0:65535];
    logic [TEXEL_W-1:0]    loaded_indices[$];
    logic [TEXEL_W-1:0]    last_loaded_index;

    bit                    idle_off = 1'b0;
    int                    stall_left = 0;
    int                    idle_cycles = 0;
    int                    error_count = 0;
    int                    loads_sent = 0;
    int                    fragments_shaded = 0;
    int                    pixels_written = 0;
    int                    widths_used = 1;

    texture_additive_blend_fragment dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (idle_off || roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // The whole word is added at once and the carries out of each channel are taken back,
    // so a carry into a channel counts towards its overflow; an overflowing channel is then
    // filled with ones, except the lowest bit of green.
    function automatic logic [TEXEL_W-1:0] add_rgb565_saturating(
        input logic [TEXEL_W-1:0] dst,
        input logic [TEXEL_W-1:0] src
    );
        logic [31:0] sum;
        logic [31:0] carry;
        sum   = 32'(dst) + 32'(src);
        carry = (sum ^ 32'(dst) ^ 32'(src)) & CHANNEL_CARRIES;
        sum   = sum - carry;
        carry = carry - (carry >> 5);
        sum   = sum | carry;
        return sum[TEXEL_W-1:0];
    endfunction

    function automatic pixel_write_t shade_pixel(input shade_request_t req);
        pixel_write_t       pix;
        logic [TEXEL_W-1:0] texel;
        int unsigned        address;
        texel   = texel_mem[{req.tex_v[23:16], req.tex_u[23:16]}];
        address = int'(req.pos_x) + int'(req.pos_y) * int'(row_length);
        pix.pixel_address = address[ADDR_W-1:0];
        if (texel != '0)
        begin
            pix.new_color    = add_rgb565_saturating(req.dest_color, texel);
            pix.write_enable = 1'b1;
        end
        else
        begin
            pix.new_color    = req.dest_color;
            pix.write_enable = 1'b0;
        end
        return pix;
    endfunction

    // Prediction on every accepted request, checking on every accepted result.
    always @(posedge clk)
    begin
        shade_request_t req;
        pixel_write_t   pix;
        pixel_word_t    word;
        if (cfg_valid && cfg_ready)
            row_length <= cfg_data;
        if (s_tvalid && s_tready)
        begin
            req = s_tdata;
            if (s_tuser == FUNC_LOAD)
            begin
                texel_mem[req.texel_index] = req.texel_value;
                pix.pixel_address = '0;
                pix.new_color     = '0;
                pix.write_enable  = 1'b0;
            end
            else
            begin
                pix = shade_pixel(req);
                fragments_shaded++;
                if (pix.write_enable)
                    pixels_written++;
            end
            expected_pixels.push_back(pix);
        end
        if (m_tvalid && m_tready)
        begin
            word = m_tdata;
            if (expected_pixels.size() == 0)
            begin
                $error("result with no request outstanding: data %h user %b", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                pix = expected_pixels.pop_front();
                if (word.pixel_address !== pix.pixel_address)
                begin
                    $error("pixel_address: expected %h, got %h",
                           pix.pixel_address, word.pixel_address);
                    error_count++;
                end
                if (word.new_color !== pix.new_color)
                begin
                    $error("new_color: expected %h, got %h", pix.new_color, word.new_color);
                    error_count++;
                end
                if (m_tuser !== pix.write_enable)
                begin
                    $error("write_enable: expected %b, got %b", pix.write_enable, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("texture_additive_blend_fragment test failed");
            $finish;
        end
    end

    task automatic send_request(input func_t func, input shade_request_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_load(input logic [TEXEL_W-1:0] index, input logic [TEXEL_W-1:0] value);
        shade_request_t req;
        req             = S_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        req.pad         = '0;
        req.texel_index = index;
        req.texel_value = value;
        if (!texel_loaded[index])
        begin
            texel_loaded[index] = 1'b1;
            loaded_indices.push_back(index);
        end
        last_loaded_index = index;
        loads_sent++;
        send_request(FUNC_LOAD, req);
    endtask

    task automatic send_fragment(
        input logic [POS_W-1:0]   x,
        input logic [POS_W-1:0]   y,
        input logic [COORD_W-1:0] u,
        input logic [COORD_W-1:0] v,
        input logic [TEXEL_W-1:0] dst
    );
        shade_request_t req;
        req             = S_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        req.pad         = '0;
        req.pos_x       = x;
        req.pos_y       = y;
        req.tex_u       = u;
        req.tex_v       = v;
        req.dest_color  = dst;
        send_request(FUNC_SHADE, req);
    endtask

    // Shades a fragment whose coordinates land on the given texel, other bits random.
    task automatic shade_texel(
        input logic [TEXEL_W-1:0] index,
        input logic [POS_W-1:0]   x,
        input logic [POS_W-1:0]   y,
        input logic [TEXEL_W-1:0] dst
    );
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        u = $urandom();
        v = $urandom();
        u[23:16] = index[7:0];
        v[23:16] = index[15:8];
        send_fragment(x, y, u, v, dst);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return POS_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [TEXEL_W-1:0] pick_colour();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return TEXEL_W'($urandom());
        endcase
    endfunction

    task automatic shade_random_fragment();
        logic [TEXEL_W-1:0] index;
        if ($urandom_range(0, 3) == 0)
            index = last_loaded_index;
        else
            index = loaded_indices[$urandom_range(0, loaded_indices.size() - 1)];
        shade_texel(index, pick_position(), pick_position(), pick_colour());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_row_length(input logic [FB_WIDTH_W-1:0] width);
        cfg_valid <= 1'b1;
        cfg_data  <= width;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        widths_used++;
    endtask

    // Saturation in each channel, zero texels, wrapped and negative coordinates.
    task automatic test_directed_blends();
        idle_off = 1'b1;
        send_load(16'h0000, 16'hFFFF);
        send_load(16'hFFFF, 16'h0001);
        send_load(16'h1234, 16'h0000);
        send_load(16'h00FF, 16'h0020);
        send_load(16'hFF00, 16'hF800);
        send_load(16'h4242, 16'h0060);
        send_fragment(10'd0, 10'd0, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        send_fragment(10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h001F);
        send_fragment(10'd1023, 10'd0, 32'h80FF_0000, 32'h8000_0000, 16'h07E0);
        send_fragment(10'd0, 10'd1023, 32'h0000_FFFF, 32'hFFFF_0000, 16'h0800);
        send_fragment(10'd5, 10'd7, 32'h7F34_FFFF, 32'h0012_0000, 16'hABCD);
        send_fragment(10'd512, 10'd511, 32'h00FF_0000, 32'h00FF_0000, 16'h0000);
        send_fragment(10'd3, 10'd2, 32'h0042_0000, 32'hC042_1234, 16'h07C0);
        send_fragment(10'd0, 10'd1, 32'h8000_0000, 32'h7F00_0000, 16'h5555);
        idle_off = 1'b0;
        drain_results();
    endtask

    task automatic test_row_lengths();
        logic [FB_WIDTH_W-1:0] widths [3];
        widths[0] = 11'd1;
        widths[1] = 11'd1024;
        widths[2] = FB_WIDTH_W'($urandom_range(2, 1023));
        foreach (widths[w])
        begin
            write_row_length(widths[w]);
            shade_texel(16'h0000, 10'd1023, 10'd1023, pick_colour());
            shade_texel(16'hFFFF, 10'd0, 10'd1023, pick_colour());
            shade_texel(16'hFF00, 10'd1023, 10'd0, pick_colour());
            for (int i = 0; i < 30; i++)
                shade_random_fragment();
            drain_results();
        end
    endtask

    // Mixed loads and fragments in chunks, each ended by a full drain.
    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            idle_off = (chunk == 2);
            for (int i = 0; i < 130; i++)
            begin
                if ($urandom_range(0, 9) < 3)
                    send_load(TEXEL_W'($urandom()),
                              ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom()));
                else
                    shade_random_fragment();
            end
            drain_results();
            write_row_length((chunk == 3) ? FB_WIDTH_RESET : 11'($urandom_range(1, 1024)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_blends();
        test_row_lengths();
        test_random_traffic();
        drain_results();
        repeat (END_PAUSE) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d results never arrived", expected_pixels.size());
            error_count++;
        end
        $display("Run covered %0d texel loads and %0d fragments, %0d of them written,",
                 loads_sent, fragments_shaded, pixels_written);
        $display("across %0d row length settings including 1 and 1024.", widths_used);
        if (error_count == 0)
            $display("texture_additive_blend_fragment test passed");
        else
            $display("texture_additive_blend_fragment test failed");
        $finish;
    end

endmodule
